// ===== rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
`default_nettype none

package deq_pkg;

	localparam int WORD_W   = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_FRONT = 2'd0,
		KIND_PUSH_REAR  = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_POP_REAR   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_HOLD = 1'b1
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/deq_ctrl.sv =====
// Handshake controller: tracks whether a result transaction is waiting at the output.
`default_nettype none

module deq_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	input  wire logic m_tready,
	output logic      s_tready,
	output logic      m_tvalid,
	output logic      take
);
	import deq_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					state_next = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (take) begin
					state_next = ST_HOLD;
				end else if (m_tready) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_HOLD: begin
				s_tready = m_tready;
				m_tvalid = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
				m_tvalid = 1'b0;
			end
		endcase
		take = s_tvalid && s_tready;
	end

endmodule

`default_nettype wire

// ===== rtl/deq_datapath.sv =====
// Ring buffer datapath: slot memory, head pointer, word count and result register.
`default_nettype none

module deq_datapath #(
	parameter  int CAPACITY = 16,
	localparam int PTR_W    = $clog2(CAPACITY),
	localparam int CNT_W    = $clog2(CAPACITY + 1),
	localparam int SUM_W    = PTR_W + 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        take,
	input  wire logic [deq_pkg::KIND_W-1:0]  kind,
	input  wire logic [deq_pkg::WORD_W-1:0]  push_value,
	output logic      [deq_pkg::WORD_W-1:0]  pop_value,
	output deq_pkg::status_t                 status,
	output logic      [CNT_W-1:0]            occupancy
);
	import deq_pkg::*;

	logic [WORD_W-1:0] slot_mem [CAPACITY];

	logic [PTR_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [WORD_W-1:0] pop_value_q;
	status_t           status_q;
	logic [CNT_W-1:0]  occupancy_q;

	logic              is_push;
	logic              is_front;
	logic              full;
	logic              empty;
	logic              do_push;
	logic              do_pop;
	logic [PTR_W-1:0]  head_prev;
	logic [PTR_W-1:0]  head_succ;
	logic [SUM_W-1:0]  tail_sum;
	logic [SUM_W-1:0]  pos_sum;
	logic [PTR_W-1:0]  rear_idx;
	logic [PTR_W-1:0]  slot_idx;
	logic [PTR_W-1:0]  head_next;
	logic [CNT_W-1:0]  count_next;
	status_t           status_next;

	always_comb begin
		is_push  = 1'b0;
		is_front = 1'b0;
		unique case (kind_t'(kind))
			KIND_PUSH_FRONT: begin
				is_push  = 1'b1;
				is_front = 1'b1;
			end
			KIND_PUSH_REAR: begin
				is_push  = 1'b1;
				is_front = 1'b0;
			end
			KIND_POP_FRONT: begin
				is_push  = 1'b0;
				is_front = 1'b1;
			end
			KIND_POP_REAR: begin
				is_push  = 1'b0;
				is_front = 1'b0;
			end
			default: begin
				is_push  = 1'b0;
				is_front = 1'b0;
			end
		endcase
	end

	always_comb begin
		full    = (count_q == CNT_W'(CAPACITY));
		empty   = (count_q == '0);
		do_push = take && is_push && !full;
		do_pop  = take && !is_push && !empty;

		head_prev = (head_q == '0) ? PTR_W'(CAPACITY - 1) : head_q - 1'b1;
		head_succ = (head_q == PTR_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

		// The rear slot to write is head + count; the rear word to read is one before it.
		tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
		pos_sum  = is_push ? tail_sum : tail_sum - 1'b1;
		rear_idx = (pos_sum >= SUM_W'(CAPACITY)) ? PTR_W'(pos_sum - SUM_W'(CAPACITY))
			: PTR_W'(pos_sum);

		if (is_front) begin
			slot_idx = is_push ? head_prev : head_q;
		end else begin
			slot_idx = rear_idx;
		end

		head_next  = head_q;
		count_next = count_q;
		if (do_push) begin
			count_next = count_q + 1'b1;
			if (is_front) begin
				head_next = head_prev;
			end
		end else if (do_pop) begin
			count_next = count_q - 1'b1;
			if (is_front) begin
				head_next = head_succ;
			end
		end

		status_next = STATUS_OK;
		if (is_push && full) begin
			status_next = STATUS_FULL;
		end else if (!is_push && empty) begin
			status_next = STATUS_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (take) begin
			head_q  <= head_next;
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_mem[slot_idx] <= push_value;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			pop_value_q <= slot_mem[slot_idx];
		end else if (take) begin
			pop_value_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q    <= status_next;
			occupancy_q <= count_next;
		end
	end

	assign pop_value = pop_value_q;
	assign status    = status_q;
	assign occupancy = occupancy_q;

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// Top level of the bounded double-ended queue with stream ports.
// Each input transaction requests a push or pop at the front or rear of a ring buffer of
// CAPACITY signed 32-bit words and produces exactly one result transaction in the next cycle,
// carrying the popped word (zero for pushes and refused requests), a status code and the
// number of stored words afterward. One request is accepted every cycle while the result
// side keeps up; a single output register holds a result under backpressure, and the input
// is taken in the same cycle that result is taken. The slot memory has one port, which each
// request uses for its single write or registered read. Slots need no clearing after reset.
`default_nettype none

module double_ended_queue #(
	parameter  int CAPACITY  = 16,
	localparam int CNT_W     = $clog2(CAPACITY + 1),
	localparam int M_TDATA_W = ((deq_pkg::WORD_W + CNT_W + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// Fields from bit 0: push_value.
	input  wire logic [deq_pkg::WORD_W-1:0]    s_tdata,
	// Fields from bit 0: kind.
	input  wire logic [deq_pkg::KIND_W-1:0]    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// Fields from bit 0: pop_value, occupancy, zero fill.
	output logic      [M_TDATA_W-1:0]          m_tdata,
	// Fields from bit 0: status.
	output logic      [deq_pkg::STATUS_W-1:0]  m_tuser
);
	import deq_pkg::*;

	logic              take;
	logic [WORD_W-1:0] pop_value;
	status_t           status;
	logic [CNT_W-1:0]  occupancy;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.m_tready (m_tready),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.take     (take)
	);

	deq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.kind       (s_tuser),
		.push_value (s_tdata),
		.pop_value  (pop_value),
		.status     (status),
		.occupancy  (occupancy)
	);

	always_comb begin
		m_tdata                  = '0;
		m_tdata[WORD_W-1:0]      = pop_value;
		m_tdata[WORD_W +: CNT_W] = occupancy;
		m_tuser                  = status;
	end

endmodule

`default_nettype wire

// ===== rtl/deq_checker.sv =====
// Port-level checks for the double-ended queue and their binding to the top level.
`default_nettype none

module deq_checker #(
	parameter  int CAPACITY  = 16,
	localparam int CNT_W     = $clog2(CAPACITY + 1),
	localparam int M_TDATA_W = ((deq_pkg::WORD_W + CNT_W + 7) / 8) * 8
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [M_TDATA_W-1:0]          m_tdata,
	input wire logic [deq_pkg::STATUS_W-1:0]  m_tuser
);
	import deq_pkg::*;

	// A stalled result must hold its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result transaction changed while stalled.");

	// Every accepted request shows its result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("Accepted request produced no result.");

	// A refused pop only happens on an empty queue and carries zero data.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_EMPTY |->
		m_tdata[WORD_W +: CNT_W] == '0 && m_tdata[WORD_W-1:0] == '0)
		else $error("Empty status with nonzero occupancy or data.");

	// A refused push only happens on a full queue and carries zero data.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_FULL |->
		m_tdata[WORD_W +: CNT_W] == CNT_W'(CAPACITY) && m_tdata[WORD_W-1:0] == '0)
		else $error("Full status with wrong occupancy or nonzero data.");

endmodule

bind double_ended_queue deq_checker #(
	.CAPACITY (CAPACITY)
) u_deq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
